[rtl/assert_macros.svh]
//------------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the timer bank control module.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Implication: when cond holds, prop holds in the same cycle.
`define ASSERT_IMP(label, cond, prop, msg) \
    `ASSERT_CLK(label, (cond) |-> (prop), msg)

// Implication: when cond holds, prop holds in the next cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
    `ASSERT_CLK(label, (cond) |=> (prop), msg)

`endif

[rtl/msft_pkg.sv]
//------------------------------------------------------------------------------
// msft_pkg
// Types and constants of the multi-channel soft timer bank.
//------------------------------------------------------------------------------
package msft_pkg;

    localparam int NUM_TIMERS  = 8;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = 32;
    localparam int IDX_W       = 8;
    localparam int OUT_IDX_W   = 3;
    localparam int TAG_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    localparam logic [TAG_W-1:0] TAG_FIRST = '0;
    localparam logic [TAG_W-1:0] TAG_LAST  = TAG_W'(NUM_TIMERS - 1);

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_STOP  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_IDX = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEEK,
        ST_TICK,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             active;
        logic             notify;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] period;
    } t_entry;

endpackage

[rtl/msft_cell.sv]
//------------------------------------------------------------------------------
// msft_cell
// One timer slot of the ring; passes its entry to the next cell on each step.
//------------------------------------------------------------------------------
module msft_cell
    import msft_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic [TAG_W-1:0] i_init_tag,
    input  t_entry           i_entry,
    output t_entry           o_entry
);

    logic [TAG_W-1:0] r_tag;
    logic             r_active;
    logic             r_notify;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag    <= i_init_tag;
            r_active <= 1'b0;
        end else if (i_adv) begin
            r_tag    <= i_entry.tag;
            r_active <= i_entry.active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_notify <= i_entry.notify;
            r_count  <= i_entry.count;
            r_period <= i_entry.period;
        end
    end

    assign o_entry = '{tag: r_tag, active: r_active, notify: r_notify,
                       count: r_count, period: r_period};

endmodule

[rtl/msft_ctrl.sv]
//------------------------------------------------------------------------------
// msft_ctrl
// Sequencer at the ring head: applies start, stop and tick to the entry
// passing the head, and holds the output register.
//------------------------------------------------------------------------------
module msft_ctrl
    import msft_pkg::*;
`include "assert_macros.svh"
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_action,
    input  logic [IDX_W-1:0]     i_timer_index,
    input  logic [CNT_W-1:0]     i_timeout_ticks,
    input  logic [CNT_W-1:0]     i_period_ticks,
    input  logic                 i_notify_on_expiry,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_result_kind,
    output logic                 o_status,
    output logic [OUT_IDX_W-1:0] o_expired_index,
    output logic                 o_last,
    input  t_entry               i_head,
    output t_entry               o_head_next,
    output logic                 o_adv
);

    t_state             r_state, n_state;
    logic               r_is_start;
    logic               r_bad;
    logic [TAG_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_timeout;
    logic [CNT_W-1:0]   r_period;
    logic               r_notify;
    logic               r_sweep, n_sweep;
    logic               r_pend_v, n_pend_v;
    logic [TAG_W-1:0]   r_pend_idx, n_pend_idx;
    logic [NRES_W-1:0]  r_nres, n_nres;
    logic               r_out_valid;
    logic               r_out_kind;
    logic               r_out_status;
    logic [OUT_IDX_W-1:0] r_out_idx;
    logic               r_out_last;

    logic               w_out_free;
    logic               w_accept;
    logic               w_seek_hit;
    logic               w_tick_step;
    logic               w_tick_end;
    logic               w_flush_done;
    logic               w_expire;
    logic               w_report;

    logic               push;
    logic               push_kind;
    logic               push_status;
    logic [OUT_IDX_W-1:0] push_idx;
    logic               push_last;

    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign o_adv        = w_out_free;
    assign o_in_stall   = (r_state != ST_IDLE);
    assign w_accept     = i_in_valid && (r_state == ST_IDLE);
    assign w_seek_hit   = w_out_free && (r_bad || (i_head.tag == r_idx));
    assign w_tick_step  = w_out_free && (r_sweep || (i_head.tag == TAG_FIRST));
    assign w_tick_end   = w_tick_step && (i_head.tag == TAG_LAST);
    assign w_flush_done = !r_pend_v || w_out_free;
    assign w_expire     = i_head.active && (i_head.count[CNT_W-1:1] == '0);
    assign w_report     = w_expire && i_head.notify && (r_nres < NRES_W'(MAX_RESULTS));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_action == ACT_START || i_action == ACT_STOP) begin
                        n_state = ST_SEEK;
                    end else if (i_action == ACT_TICK) begin
                        n_state = ST_TICK;
                    end
                end
            end
            ST_SEEK: begin
                if (w_seek_hit) begin
                    n_state = ST_IDLE;
                end
            end
            ST_TICK: begin
                if (w_tick_end) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (w_flush_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_head_next = i_head;
        n_sweep     = r_sweep;
        n_pend_v    = r_pend_v;
        n_pend_idx  = r_pend_idx;
        n_nres      = r_nres;
        push        = 1'b0;
        push_kind   = KIND_STATUS;
        push_status = STATUS_OK;
        push_idx    = '0;
        push_last   = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                n_sweep  = 1'b0;
                n_pend_v = 1'b0;
                n_nres   = '0;
            end
            ST_SEEK: begin
                if (w_seek_hit) begin
                    if (r_bad) begin
                        if (r_is_start) begin
                            push        = 1'b1;
                            push_status = STATUS_BAD_IDX;
                        end
                    end else if (r_is_start) begin
                        o_head_next.active = 1'b1;
                        o_head_next.notify = r_notify;
                        o_head_next.count  = r_timeout;
                        o_head_next.period = r_period;
                        push     = 1'b1;
                        push_idx = OUT_IDX_W'(r_idx);
                    end else begin
                        o_head_next.active = 1'b0;
                    end
                end
            end
            ST_TICK: begin
                if (w_tick_step) begin
                    n_sweep = !w_tick_end;
                    if (i_head.active) begin
                        if (!w_expire) begin
                            o_head_next.count = i_head.count - CNT_W'(1);
                        end else if (i_head.period != '0) begin
                            o_head_next.count = i_head.period;
                        end else begin
                            o_head_next.count  = '0;
                            o_head_next.active = 1'b0;
                        end
                    end
                    if (w_report) begin
                        if (r_pend_v) begin
                            push      = 1'b1;
                            push_kind = KIND_EXPIRY;
                            push_idx  = OUT_IDX_W'(r_pend_idx);
                            push_last = 1'b0;
                        end
                        n_pend_v   = 1'b1;
                        n_pend_idx = i_head.tag;
                        n_nres     = r_nres + NRES_W'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (r_pend_v && w_out_free) begin
                    push      = 1'b1;
                    push_kind = KIND_EXPIRY;
                    push_idx  = OUT_IDX_W'(r_pend_idx);
                    n_pend_v  = 1'b0;
                end
            end
            default: begin
                n_sweep = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sweep     <= 1'b0;
            r_pend_v    <= 1'b0;
            r_nres      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sweep  <= n_sweep;
            r_pend_v <= n_pend_v;
            r_nres   <= n_nres;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        if (w_accept) begin
            r_is_start <= (i_action == ACT_START);
            r_bad      <= (i_timer_index >= IDX_W'(NUM_TIMERS));
            r_idx      <= i_timer_index[TAG_W-1:0];
            r_timeout  <= i_timeout_ticks;
            r_period   <= i_period_ticks;
            r_notify   <= i_notify_on_expiry;
        end
        if (push) begin
            r_out_kind   <= push_kind;
            r_out_status <= push_status;
            r_out_idx    <= push_idx;
            r_out_last   <= push_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_out_kind;
    assign o_status        = r_out_status;
    assign o_expired_index = r_out_idx;
    assign o_last          = r_out_last;

    `ASSERT_IMP(a_idle_no_pend, r_state == ST_IDLE, !r_pend_v, "pending expiry left at idle")
    `ASSERT_CLK(a_nres_cap, r_nres <= NRES_W'(MAX_RESULTS), "expiry count above cap")
    `ASSERT_IMP(a_sweep_in_tick, r_sweep, r_state == ST_TICK, "sweep flag outside tick")
    `ASSERT_NEXT(a_push_free, push, r_out_valid, "pushed item lost")

endmodule

[rtl/multi_channel_soft_timer_top.sv]
//------------------------------------------------------------------------------
// multi_channel_soft_timer_top
// Bank of countdown timers kept in a rotating ring of cells.
//
//   channel | valid       | stall       | fields
//   --------+-------------+-------------+-------------------------------------
//   in      | i_in_valid  | o_in_stall  | action, timer_index, timeout/period,
//           |             |             | notify_on_expiry
//   out     | o_out_valid | i_out_stall | result_kind, status, expired_index,
//           |             |             | last
//
// The ring steps one cell per cycle; the head sequencer touches one timer
// per step. Accept to next accept: start/stop wait for the slot to reach
// the head; a tick waits for the first timer, then sweeps every timer
// through the head. Output stalls lengthen both.
// Synchronous reset clears all active marks; counts are undefined until
// a start. The ring holds still while the output register is stalled.
//------------------------------------------------------------------------------
module multi_channel_soft_timer_top
    import msft_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_action,
    input  logic [IDX_W-1:0]     i_timer_index,
    input  logic [CNT_W-1:0]     i_timeout_ticks,
    input  logic [CNT_W-1:0]     i_period_ticks,
    input  logic                 i_notify_on_expiry,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_result_kind,
    output logic                 o_status,
    output logic [OUT_IDX_W-1:0] o_expired_index,
    output logic                 o_last
);

    t_entry w_cell [NUM_TIMERS];
    t_entry w_head_next;
    logic   w_adv;

    for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_ring
        msft_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (w_adv),
            .i_init_tag (TAG_W'(NUM_TIMERS - 1 - k)),
            .i_entry    ((k == 0) ? w_head_next : w_cell[(k == 0) ? 0 : k - 1]),
            .o_entry    (w_cell[k])
        );
    end

    msft_ctrl u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_action           (i_action),
        .i_timer_index      (i_timer_index),
        .i_timeout_ticks    (i_timeout_ticks),
        .i_period_ticks     (i_period_ticks),
        .i_notify_on_expiry (i_notify_on_expiry),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_result_kind      (o_result_kind),
        .o_status           (o_status),
        .o_expired_index    (o_expired_index),
        .o_last             (o_last),
        .i_head             (w_cell[NUM_TIMERS-1]),
        .o_head_next        (w_head_next),
        .o_adv              (w_adv)
    );

endmodule

[bench/multi_channel_soft_timer_top_tb.sv]
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// multi_channel_soft_timer_top_tb
// Self-checking bench for the countdown timer bank. A queue of start, stop
// and tick items feeds a clocked driver; a shadow copy of the timer bank
// predicts the status and expiry results of each accepted item, and a
// clocked monitor compares every result against the oldest prediction.
// Both sides idle in random bursts, except near the end of the run.
//------------------------------------------------------------------------------
module multi_channel_soft_timer_top_tb;
    import msft_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 4 * NUM_TIMERS + 8;
    localparam int RANDOM_ITEMS = 250;
    localparam int CALM_ITEMS = 40;
    localparam logic [CNT_W-1:0] ALL_ONES = '1;

    typedef struct {
        logic [1:0]       action;
        logic [IDX_W-1:0] index;
        logic [CNT_W-1:0] timeout;
        logic [CNT_W-1:0] period;
        logic             notify;
        bit               drain;
    } t_timer_cmd;

    typedef struct packed {
        logic                 kind;
        logic                 status;
        logic [OUT_IDX_W-1:0] index;
        logic                 last;
    } t_timer_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [1:0]           i_action = ACT_TICK;
    logic [IDX_W-1:0]     i_timer_index = '0;
    logic [CNT_W-1:0]     i_timeout_ticks = '0;
    logic [CNT_W-1:0]     i_period_ticks = '0;
    logic                 i_notify_on_expiry = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_result_kind;
    logic                 o_status;
    logic [OUT_IDX_W-1:0] o_expired_index;
    logic                 o_last;

    t_timer_cmd    stim_items[$];
    t_timer_result expected_results[$];

    logic             bank_active[NUM_TIMERS];
    logic [CNT_W-1:0] bank_count[NUM_TIMERS];
    logic [CNT_W-1:0] bank_period[NUM_TIMERS];
    logic             bank_notify[NUM_TIMERS];

    int err_count = 0;
    int cycle_count = 0;
    int burst_pct = 0;

    multi_channel_soft_timer_top u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_action           (i_action),
        .i_timer_index      (i_timer_index),
        .i_timeout_ticks    (i_timeout_ticks),
        .i_period_ticks     (i_period_ticks),
        .i_notify_on_expiry (i_notify_on_expiry),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_result_kind      (o_result_kind),
        .o_status           (o_status),
        .o_expired_index    (o_expired_index),
        .o_last             (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Shadow timer bank: updates state and queues the results of one item.
    function automatic void predict_timer_results(input t_timer_cmd c);
        t_timer_result r;
        int n;
        n = 0;
        r.kind = KIND_STATUS;
        r.status = STATUS_OK;
        r.index = '0;
        r.last = 1'b1;
        case (c.action)
            ACT_START: begin
                if (c.index < NUM_TIMERS) begin
                    bank_active[c.index] = 1'b1;
                    bank_count[c.index] = c.timeout;
                    bank_period[c.index] = c.period;
                    bank_notify[c.index] = c.notify;
                    r.index = OUT_IDX_W'(c.index);
                end else begin
                    r.status = STATUS_BAD_IDX;
                end
                expected_results.push_back(r);
            end
            ACT_STOP: begin
                if (c.index < NUM_TIMERS)
                    bank_active[c.index] = 1'b0;
            end
            ACT_TICK: begin
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (bank_active[i]) begin
                        if (bank_count[i] != 0)
                            bank_count[i] = bank_count[i] - 1;
                        if (bank_count[i] == 0) begin
                            if (bank_notify[i] && n < MAX_RESULTS) begin
                                r.kind = KIND_EXPIRY;
                                r.status = STATUS_OK;
                                r.index = OUT_IDX_W'(i);
                                r.last = 1'b0;
                                expected_results.push_back(r);
                                n++;
                            end
                            if (bank_period[i] != 0)
                                bank_count[i] = bank_period[i];
                            else
                                bank_active[i] = 1'b0;
                        end
                    end
                end
                if (n > 0)
                    expected_results[expected_results.size() - 1].last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    function automatic void add_cmd(input logic [1:0] action, input int index,
                                    input logic [CNT_W-1:0] timeout,
                                    input logic [CNT_W-1:0] period,
                                    input logic notify, input bit drain);
        t_timer_cmd c;
        c.action = action;
        c.index = IDX_W'(index);
        c.timeout = timeout;
        c.period = period;
        c.notify = notify;
        c.drain = drain;
        stim_items.push_back(c);
    endfunction

    // Driver
    always @(posedge i_clk) begin
        bit loaded;
        int gap_left;
        t_timer_cmd c;
        if (!i_rst_n) begin
            loaded = 1'b0;
            gap_left = 0;
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_timer_results(c);
                loaded = 1'b0;
                if (stim_items.size() >= CALM_ITEMS && $urandom_range(0, 99) < burst_pct)
                    gap_left = $urandom_range(1, 6);
            end else if (gap_left > 0) begin
                gap_left--;
            end
            if (!loaded && gap_left == 0 && stim_items.size() > 0) begin
                if (!stim_items[0].drain || expected_results.size() == 0) begin
                    c = stim_items.pop_front();
                    loaded = 1'b1;
                    i_action <= c.action;
                    i_timer_index <= c.index;
                    i_timeout_ticks <= c.timeout;
                    i_period_ticks <= c.period;
                    i_notify_on_expiry <= c.notify;
                end
            end
            i_in_valid <= loaded;
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        int stall_left;
        t_timer_result got;
        t_timer_result want;
        if (!i_rst_n) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got.kind = o_result_kind;
                got.status = o_status;
                got.index = o_expired_index;
                got.last = o_last;
                if (expected_results.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected result: kind=%0d status=%0d index=%0d last=%0d",
                                 got.kind, got.status, got.index, got.last);
                end else begin
                    want = expected_results.pop_front();
                    if (got != want) begin
                        err_count++;
                        if (err_count <= 10) begin
                            $display("mismatch: expected kind=%0d status=%0d index=%0d last=%0d",
                                     want.kind, want.status, want.index, want.last);
                            $display("          got kind=%0d status=%0d index=%0d last=%0d",
                                     got.kind, got.status, got.index, got.last);
                        end
                    end
                end
            end
            if (stall_left > 0)
                stall_left--;
            else if (stim_items.size() >= CALM_ITEMS && $urandom_range(0, 399) < burst_pct)
                stall_left = $urandom_range(1, 6);
            i_out_stall <= (stall_left > 0);
        end
    end

    // Cycle limit and idle-rate phases
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count % 64 == 0) begin
            case ($urandom_range(0, 2))
                0: burst_pct <= 0;
                1: burst_pct <= 10;
                default: burst_pct <= 35;
            endcase
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("multi_channel_soft_timer_top_tb: done, errors");
            $finish;
        end
    end

    initial begin
        int counted;
        int pick;
        logic [1:0] act;
        int idx;
        logic [CNT_W-1:0] tmo;
        logic [CNT_W-1:0] per;

        foreach (bank_active[i])
            bank_active[i] = 1'b0;

        // directed
        add_cmd(ACT_START, 0, 0, 0, 1'b1, 0);
        add_cmd(ACT_START, 1, 1, 2, 1'b1, 0);
        add_cmd(ACT_START, 2, 1, 0, 1'b1, 0);
        add_cmd(ACT_START, 3, 1, 1, 1'b1, 0);
        add_cmd(ACT_START, 4, 1, 1, 1'b1, 0);
        add_cmd(ACT_START, 5, 1, 1, 1'b1, 0);
        add_cmd(ACT_START, 6, 1, 1, 1'b1, 0);
        add_cmd(ACT_START, 7, 1, ALL_ONES, 1'b1, 0);
        add_cmd(ACT_START, NUM_TIMERS, 5, 5, 1'b0, 0);
        add_cmd(ACT_START, 255, ALL_ONES, ALL_ONES, 1'b1, 0);
        add_cmd(ACT_STOP, 255, ALL_ONES, ALL_ONES, 1'b1, 0);
        add_cmd(ACT_UNUSED, 255, ALL_ONES, ALL_ONES, 1'b1, 0);
        add_cmd(ACT_TICK, 0, 0, 0, 1'b0, 0);
        add_cmd(ACT_TICK, 255, ALL_ONES, ALL_ONES, 1'b1, 1);
        add_cmd(ACT_START, 5, 0, 0, 1'b0, 0);
        add_cmd(ACT_STOP, 3, 0, 0, 1'b0, 0);
        add_cmd(ACT_STOP, 4, 0, 0, 1'b0, 0);
        add_cmd(ACT_STOP, 6, 0, 0, 1'b0, 0);
        add_cmd(ACT_TICK, 0, 0, 0, 1'b0, 0);
        add_cmd(ACT_STOP, 1, 0, 0, 1'b0, 0);
        add_cmd(ACT_TICK, 0, 0, 0, 1'b0, 0);
        add_cmd(ACT_START, 7, ALL_ONES, 0, 1'b0, 0);

        // random
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                act = ACT_START;
            else if (pick < 50)
                act = ACT_STOP;
            else if (pick < 96)
                act = ACT_TICK;
            else
                act = ACT_UNUSED;
            idx = ($urandom_range(0, 99) < 85) ? $urandom_range(0, NUM_TIMERS - 1)
                                               : $urandom_range(0, 255);
            tmo = $urandom;
            per = $urandom;
            if (act == ACT_START) begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    tmo = $urandom_range(0, 6);
                else if (pick < 90)
                    tmo = $urandom_range(0, 255);
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    per = 0;
                else if (pick < 85)
                    per = $urandom_range(1, 5);
            end
            add_cmd(act, idx, tmo, per, 1'($urandom_range(0, 1)),
                    $urandom_range(0, 49) == 0);
            if (act != ACT_UNUSED)
                counted++;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_items.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        err_count += expected_results.size();
        if (err_count == 0)
            $display("multi_channel_soft_timer_top_tb: done, clean");
        else
            $display("multi_channel_soft_timer_top_tb: done, errors");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/msft_pkg.sv
rtl/msft_cell.sv
rtl/msft_ctrl.sv
rtl/multi_channel_soft_timer_top.sv
bench/multi_channel_soft_timer_top_tb.sv
